// ===== src/wsa_pkg.sv =====
package wsa_pkg;

  localparam int GRID_SIDE = 64;
  localparam int CW        = $clog2(GRID_SIDE);
  localparam int CELLS     = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AW        = $clog2(CELLS);
  localparam int MID       = GRID_SIDE / 2;
  localparam int DW        = 12;
  localparam int RW        = DW / 2;
  localparam int CFG_IW    = 3;

  localparam logic [DW-1:0] UNREACHED   = 12'hFFF;
  localparam logic [AW-1:0] CENTRE_ADDR = AW'((MID * GRID_SIDE + MID) * GRID_SIDE + MID);
  localparam logic [CW-1:0] COORD_LAST  = CW'(GRID_SIDE - 1);
  localparam logic [CW-1:0] COORD_MID   = CW'(MID);

  // configuration register indexes
  localparam logic [CFG_IW-1:0] REG_PULSE_MIN      = 3'd0;
  localparam logic [CFG_IW-1:0] REG_PULSE_MAX      = 3'd1;
  localparam logic [CFG_IW-1:0] REG_INTERACT_WIDTH = 3'd2;
  localparam logic [CFG_IW-1:0] REG_VISUAL_FLOOR   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_VISUAL_CEILING = 3'd4;

  localparam logic [DW-1:0] RST_PULSE_MIN      = 12'd0;
  localparam logic [DW-1:0] RST_PULSE_MAX      = 12'd1024;
  localparam logic [DW-1:0] RST_INTERACT_WIDTH = 12'd1;
  localparam logic [DW-1:0] RST_VISUAL_FLOOR   = 12'd5;
  localparam logic [DW-1:0] RST_VISUAL_CEILING = 12'd200;

  // command kinds
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_READ = 2'd1;
  localparam logic [1:0] CMD_OOB  = 2'd2;

  typedef struct packed {
    logic [1:0]    kind;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
  } cmd_t;

  typedef struct packed {
    logic [DW-1:0] pulse_min;
    logic [DW-1:0] pulse_max;
    logic [DW-1:0] interact_width;
    logic [DW-1:0] visual_floor;
    logic [DW-1:0] visual_ceiling;
  } cfg_t;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                               input logic [CW-1:0] y,
                                               input logic [CW-1:0] z);
    cell_addr = (AW'(x) * AW'(GRID_SIDE) + AW'(y)) * AW'(GRID_SIDE) + AW'(z);
  endfunction

  function automatic logic [CW-1:0] offset_of(input logic [CW-1:0] c);
    offset_of = (c > COORD_MID) ? c - COORD_MID : COORD_MID - c;
  endfunction

endpackage

// ===== src/wsa_ifs.sv =====
interface wsa_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [5:0] cell_x;
  logic [5:0] cell_y;
  logic [5:0] cell_z;
  modport source (output valid, req_type, cell_x, cell_y, cell_z, input ready);
  modport sink   (input valid, req_type, cell_x, cell_y, cell_z, output ready);
endinterface

interface wsa_rsp_if;
  logic        valid;
  logic        ready;
  logic [11:0] pulse_value;
  logic [11:0] cell_dist;
  logic        cell_interact;
  logic        cell_visual;
  modport source (output valid, pulse_value, cell_dist, cell_interact, cell_visual,
                  input ready);
  modport sink   (input valid, pulse_value, cell_dist, cell_interact, cell_visual,
                  output ready);
endinterface

interface wsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [11:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ===== src/wsa_front.sv =====
module wsa_front (
  input  logic          clk,
  input  logic          rst,
  wsa_req_if.sink       req,
  wsa_cfg_if.sink       cfg,
  output wsa_pkg::cfg_t regs,
  output logic          cmd_valid,
  output wsa_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import wsa_pkg::*;

  cmd_t       q [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       in_grid;
  cmd_t       cmd_in;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign in_grid = (32'(req.cell_x) < GRID_SIDE) && (32'(req.cell_y) < GRID_SIDE) &&
                   (32'(req.cell_z) < GRID_SIDE);

  always_comb begin
    cmd_in.x = CW'(req.cell_x);
    cmd_in.y = CW'(req.cell_y);
    cmd_in.z = CW'(req.cell_z);
    if (!req.req_type) begin
      cmd_in.kind = CMD_TICK;
    end else if (in_grid) begin
      cmd_in.kind = CMD_READ;
    end else begin
      cmd_in.kind = CMD_OOB;
    end
  end

  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cmd_in;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (cmd_pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pulse_min      <= RST_PULSE_MIN;
      regs.pulse_max      <= RST_PULSE_MAX;
      regs.interact_width <= RST_INTERACT_WIDTH;
      regs.visual_floor   <= RST_VISUAL_FLOOR;
      regs.visual_ceiling <= RST_VISUAL_CEILING;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_PULSE_MIN:      regs.pulse_min      <= cfg.wdata;
        REG_PULSE_MAX:      regs.pulse_max      <= cfg.wdata;
        REG_INTERACT_WIDTH: regs.interact_width <= cfg.wdata;
        REG_VISUAL_FLOOR:   regs.visual_floor   <= cfg.wdata;
        REG_VISUAL_CEILING: regs.visual_ceiling <= cfg.wdata;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/wsa_isqrt.sv =====
module wsa_isqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [wsa_pkg::DW-1:0]  n,
  output logic                    done,
  output logic [wsa_pkg::RW-1:0]  root
);
  import wsa_pkg::*;

  localparam int BW = $clog2(RW);

  logic [DW-1:0] num;
  logic [BW-1:0] bitpos;
  logic          busy;
  logic [RW-1:0] trial;
  logic [DW-1:0] sq;

  assign trial = root | (RW'(1) << bitpos);
  assign sq    = DW'(trial) * DW'(trial);
  assign done  = !busy;

  // one result bit per cycle, MSB first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && bitpos == '0) begin
      busy <= 1'b0;
    end
    if (start) begin
      num    <= n;
      root   <= '0;
      bitpos <= BW'(RW - 1);
    end else if (busy) begin
      if (sq <= num) begin
        root <= trial;
      end
      bitpos <= bitpos - 1'b1;
    end
  end

endmodule

// ===== src/wsa_back.sv =====
module wsa_back (
  input  logic          clk,
  input  logic          rst,
  input  wsa_pkg::cfg_t regs,
  input  logic          cmd_valid,
  input  wsa_pkg::cmd_t cmd,
  output logic          cmd_pop,
  wsa_rsp_if.source     rsp
);
  import wsa_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TICK  = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;

  localparam logic [2:0] K_SELF = 3'd0;
  localparam logic [2:0] K_XP   = 3'd1;
  localparam logic [2:0] K_XM   = 3'd2;
  localparam logic [2:0] K_YP   = 3'd3;
  localparam logic [2:0] K_YM   = 3'd4;
  localparam logic [2:0] K_ZP   = 3'd5;
  localparam logic [2:0] K_ZM   = 3'd6;

  logic [2:0]    state;
  logic [DW-1:0] phase;
  logic          falling;
  logic          cur;
  logic          fresh;
  logic          ticked;
  logic [DW-1:0] snap_pulse;
  logic [DW-1:0] snap_iw;
  logic [DW-1:0] snap_thick;

  logic [CW-1:0] sx, sy, sz;
  logic [2:0]    k;

  logic          p_valid;
  logic [2:0]    p_k;
  logic          p_exists;
  logic [CW-1:0] p_a;
  logic [AW-1:0] p_naddr;
  logic [AW-1:0] p_dst;
  logic [DW-1:0] acc;
  logic [AW-1:0] rd_addr;

  logic          res_valid;
  logic [DW-1:0] res_pulse;
  logic [DW-1:0] res_dist;
  logic          res_interact;
  logic          res_visual;

  logic [DW-1:0] mem0 [CELLS];
  logic [DW-1:0] mem1 [CELLS];
  logic [DW-1:0] rd0, rd1, rdata;
  logic [AW-1:0] ra;
  logic          we;
  logic [DW-1:0] wd;

  logic [CW-1:0] nx, ny, nz, n_a;
  logic          n_exists;
  logic [DW-1:0] src;
  logic [DW:0]   cand;
  logic [DW-1:0] acc_new;

  logic [DW-1:0] phase_next;
  logic          falling_next;
  logic          sq_start;
  logic          sq_done;
  logic [RW-1:0] sq_root;
  logic [DW-1:0] thick;
  logic [DW-1:0] rd_src;
  logic [DW-1:0] dist_d;

  assign rsp.valid         = res_valid;
  assign rsp.pulse_value   = res_pulse;
  assign rsp.cell_dist     = res_dist;
  assign rsp.cell_interact = res_interact;
  assign rsp.cell_visual   = res_visual;

  assign cmd_pop = (state == ST_IDLE) && cmd_valid && !res_valid;

  // neighbor to fetch this cycle
  always_comb begin
    nx = sx;
    ny = sy;
    nz = sz;
    n_exists = 1'b1;
    case (k)
      K_XP: begin nx = sx + 1'b1; n_exists = (sx != COORD_LAST); end
      K_XM: begin nx = sx - 1'b1; n_exists = (sx != '0); end
      K_YP: begin ny = sy + 1'b1; n_exists = (sy != COORD_LAST); end
      K_YM: begin ny = sy - 1'b1; n_exists = (sy != '0); end
      K_ZP: begin nz = sz + 1'b1; n_exists = (sz != COORD_LAST); end
      K_ZM: begin nz = sz - 1'b1; n_exists = (sz != '0); end
      default: ;
    endcase
    case (k)
      K_XP, K_XM: n_a = offset_of(nx);
      K_YP, K_YM: n_a = offset_of(ny);
      default:    n_a = offset_of(nz);
    endcase
  end

  assign ra = (state == ST_SWEEP) ? cell_addr(nx, ny, nz) : cell_addr(cmd.x, cmd.y, cmd.z);

  // both banks are unreached-with-zero-centre until the first tick writes one
  assign rdata = cur ? rd1 : rd0;
  assign src   = fresh ? ((p_naddr == CENTRE_ADDR) ? '0 : UNREACHED) : rdata;
  assign cand  = {1'b0, src} + {1'b0, DW'({p_a, 1'b1})};

  always_comb begin
    if (p_k == K_SELF) begin
      acc_new = src;
    end else if (p_exists && cand < {1'b0, acc}) begin
      acc_new = cand[DW-1:0];
    end else begin
      acc_new = acc;
    end
  end

  assign we = p_valid && (p_k == K_ZM);
  assign wd = (p_dst == CENTRE_ADDR) ? '0 : acc_new;

  always_ff @(posedge clk) begin
    if (we && cur) begin
      mem0[p_dst] <= wd;
    end
    if (we && !cur) begin
      mem1[p_dst] <= wd;
    end
    rd0 <= mem0[ra];
    rd1 <= mem1[ra];
  end

  // triangle pulse step
  always_comb begin
    phase_next   = phase;
    falling_next = falling;
    if (!falling) begin
      if (phase < regs.pulse_max) begin
        phase_next = phase + 1'b1;
      end else begin
        falling_next = 1'b1;
        if (phase != '0) phase_next = phase - 1'b1;
      end
    end else begin
      if (phase > regs.pulse_min) begin
        phase_next = phase - 1'b1;
      end else begin
        falling_next = 1'b0;
        if (phase < regs.pulse_max) phase_next = phase + 1'b1;
      end
    end
  end

  assign sq_start = (state == ST_TICK);

  wsa_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .n     (phase_next),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_comb begin
    thick = DW'({sq_root, 1'b1});
    if (thick < regs.visual_floor) thick = regs.visual_floor;
    if (thick > regs.visual_ceiling) thick = regs.visual_ceiling;
  end

  assign rd_src = fresh ? ((rd_addr == CENTRE_ADDR) ? '0 : UNREACHED) : rdata;
  assign dist_d = (rd_src > snap_pulse) ? rd_src - snap_pulse : snap_pulse - rd_src;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= RST_PULSE_MIN;
      falling   <= 1'b0;
      cur       <= 1'b0;
      fresh     <= 1'b1;
      ticked    <= 1'b0;
      p_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      p_valid <= (state == ST_SWEEP);
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            case (cmd.kind)
              CMD_TICK: state <= ST_TICK;
              CMD_READ: state <= ST_READ;
              default: begin
                res_valid    <= 1'b1;
                res_pulse    <= phase;
                res_dist     <= UNREACHED;
                res_interact <= 1'b0;
                res_visual   <= 1'b0;
              end
            endcase
          end
        end
        ST_TICK: begin
          phase   <= phase_next;
          falling <= falling_next;
          state   <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (k == K_ZM && sx == COORD_LAST && sy == COORD_LAST && sz == COORD_LAST) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (sq_done) begin
            cur          <= ~cur;
            fresh        <= 1'b0;
            ticked       <= 1'b1;
            snap_pulse   <= phase;
            snap_iw      <= regs.interact_width;
            snap_thick   <= thick;
            res_valid    <= 1'b1;
            res_pulse    <= phase;
            res_dist     <= '0;
            res_interact <= 1'b0;
            res_visual   <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        ST_READ: begin
          res_valid    <= 1'b1;
          res_pulse    <= phase;
          res_dist     <= rd_src;
          res_interact <= ticked && (rd_src != UNREACHED) && (dist_d <= snap_iw);
          res_visual   <= ticked && (rd_src != UNREACHED) && (dist_d <= snap_thick);
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // sweep counters and the fetch-to-accumulate stage
  always_ff @(posedge clk) begin
    if (state == ST_TICK) begin
      sx <= '0;
      sy <= '0;
      sz <= '0;
      k  <= K_SELF;
    end else if (state == ST_SWEEP) begin
      if (k == K_ZM) begin
        k <= K_SELF;
        if (sz == COORD_LAST) begin
          sz <= '0;
          if (sy == COORD_LAST) begin
            sy <= '0;
            sx <= sx + 1'b1;
          end else begin
            sy <= sy + 1'b1;
          end
        end else begin
          sz <= sz + 1'b1;
        end
      end else begin
        k <= k + 1'b1;
      end
    end
    if (cmd_pop) begin
      rd_addr <= ra;
    end
    p_k      <= k;
    p_exists <= n_exists;
    p_a      <= n_a;
    p_naddr  <= ra;
    p_dst    <= cell_addr(sx, sy, sz);
    if (p_valid) begin
      acc <= acc_new;
    end
  end

endmodule

// ===== src/wavefront_shell_automaton.sv =====
// Channel | Dir | Fields
// req     | in  | req_type, cell_x, cell_y, cell_z
// rsp     | out | pulse_value, cell_dist, cell_interact, cell_visual
// cfg     | in  | reg_index, wdata (always ready)
//
// A tick runs the relax sweep: one single-port read of the distance bank per cell and
// per neighbor. Two distance banks ping-pong; no clearing pass is needed after reset.
// Reset is synchronous. A two-beat queue keeps req open while the back end works
// or while rsp is stalled.
module wavefront_shell_automaton (
  input  logic      clk,
  input  logic      rst,
  wsa_req_if.sink   req,
  wsa_rsp_if.source rsp,
  wsa_cfg_if.sink   cfg
);
  import wsa_pkg::*;

  cfg_t regs;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  wsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .regs      (regs),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  wsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp       (rsp)
  );

endmodule

// ===== test/wsa_tb_ifs.sv =====
`timescale 1ns / 1ps

// Side-band controls shared by the bench processes.
interface wsa_tb_ctl;
  logic quiet;
  int   hold_req;
endinterface

// ===== test/wavefront_shell_automaton_tb.sv =====
`timescale 1ns / 1ps

module wavefront_shell_automaton_tb;
  import wsa_pkg::*;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_READ = 1'b1;
  localparam int   IDLE_LIMIT = 8_000_000;  // longer than one tick sweep
  localparam int   LONG_HOLD = 300;

  typedef struct {
    logic [DW-1:0] pulse;
    logic [DW-1:0] dist_val;
    logic          interact;
    logic          visual;
  } cell_rsp_t;

  class shell_scoreboard;
    logic [DW-1:0] dist_grid [CELLS];
    logic [DW-1:0] scratch [CELLS];
    logic [1:0]    flag_grid [CELLS];
    logic [DW-1:0] phase;
    logic          falling;
    logic [DW-1:0] lo_turn, hi_turn, thin_w, vis_floor, vis_ceil;
    cell_rsp_t     pending_rsp [$];
    int            errors, ticks, reads, rsps;

    function new();
      for (int i = 0; i < CELLS; i++) begin
        dist_grid[i] = UNREACHED;
        flag_grid[i] = 2'b00;
      end
      dist_grid[CENTRE_ADDR] = '0;
      lo_turn = RST_PULSE_MIN;
      hi_turn = RST_PULSE_MAX;
      thin_w = RST_INTERACT_WIDTH;
      vis_floor = RST_VISUAL_FLOOR;
      vis_ceil = RST_VISUAL_CEILING;
      phase = RST_PULSE_MIN;
      falling = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [DW-1:0] val);
      case (idx)
        REG_PULSE_MIN:      lo_turn = val;
        REG_PULSE_MAX:      hi_turn = val;
        REG_INTERACT_WIDTH: thin_w = val;
        REG_VISUAL_FLOOR:   vis_floor = val;
        REG_VISUAL_CEILING: vis_ceil = val;
        default: ;
      endcase
    endfunction

    function int axis_off(int c);
      return (c > MID) ? c - MID : MID - c;
    endfunction

    function void relax(int dst, int v, int a);
      int cand;
      cand = v + 2 * a + 1;
      if (cand < scratch[dst]) scratch[dst] = DW'(cand);
    endfunction

    function void advance_wavefront();
      int r, thick, v, d, i;
      if (!falling) begin
        if (phase < hi_turn) phase++;
        else begin
          falling = 1'b1;
          if (phase > 0) phase--;
        end
      end else begin
        if (phase > lo_turn) phase--;
        else begin
          falling = 1'b0;
          if (phase < hi_turn) phase++;
        end
      end
      scratch = dist_grid;
      for (int x = 0; x < GRID_SIDE; x++)
        for (int y = 0; y < GRID_SIDE; y++)
          for (int z = 0; z < GRID_SIDE; z++) begin
            i = (x * GRID_SIDE + y) * GRID_SIDE + z;
            v = dist_grid[i];
            if (v == UNREACHED) continue;
            if (x + 1 < GRID_SIDE) relax(i + GRID_SIDE * GRID_SIDE, v, axis_off(x));
            if (x > 0)             relax(i - GRID_SIDE * GRID_SIDE, v, axis_off(x));
            if (y + 1 < GRID_SIDE) relax(i + GRID_SIDE, v, axis_off(y));
            if (y > 0)             relax(i - GRID_SIDE, v, axis_off(y));
            if (z + 1 < GRID_SIDE) relax(i + 1, v, axis_off(z));
            if (z > 0)             relax(i - 1, v, axis_off(z));
          end
      scratch[CENTRE_ADDR] = '0;
      dist_grid = scratch;
      r = 0;
      while ((r + 1) * (r + 1) <= phase) r++;
      thick = 2 * r + 1;
      if (thick < vis_floor) thick = vis_floor;
      if (thick > vis_ceil) thick = vis_ceil;
      for (int k = 0; k < CELLS; k++) begin
        v = dist_grid[k];
        flag_grid[k] = 2'b00;
        if (v != UNREACHED) begin
          d = (v > phase) ? v - phase : phase - v;
          flag_grid[k][0] = (d <= thin_w);
          flag_grid[k][1] = (d <= thick);
        end
      end
    endfunction

    function void note_request(logic kind, logic [5:0] x, logic [5:0] y, logic [5:0] z);
      cell_rsp_t e;
      int i;
      e = '{pulse: '0, dist_val: '0, interact: 1'b0, visual: 1'b0};
      if (kind == REQ_TICK) begin
        advance_wavefront();
        ticks++;
      end else begin
        i = (int'(x) * GRID_SIDE + int'(y)) * GRID_SIDE + int'(z);
        e.dist_val = dist_grid[i];
        e.interact = flag_grid[i][0];
        e.visual = flag_grid[i][1];
        reads++;
      end
      e.pulse = phase;
      pending_rsp.push_back(e);
    endfunction

    function void check_result(logic [DW-1:0] pv, logic [DW-1:0] cd, logic ci, logic cv);
      cell_rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("response beat with nothing outstanding");
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      rsps++;
      if (pv !== e.pulse) begin
        $error("pulse_value exp %0d got %0d", e.pulse, pv);
        errors++;
      end
      if (cd !== e.dist_val) begin
        $error("cell_dist exp %0d got %0d", e.dist_val, cd);
        errors++;
      end
      if (ci !== e.interact) begin
        $error("cell_interact exp %0b got %0b", e.interact, ci);
        errors++;
      end
      if (cv !== e.visual) begin
        $error("cell_visual exp %0b got %0b", e.visual, cv);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  wsa_req_if req ();
  wsa_rsp_if rsp ();
  wsa_cfg_if cfg ();
  wsa_tb_ctl ctl ();

  wavefront_shell_automaton DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  shell_scoreboard sb = new();
  int idle_cycles = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_READ;
    req.cell_x = '0;
    req.cell_y = '0;
    req.cell_z = '0;
    cfg.valid = 1'b0;
    cfg.reg_index = '0;
    cfg.wdata = '0;
    rsp.ready = 1'b0;
    ctl.quiet = 1'b0;
    ctl.hold_req = 0;
  end

  // response side: random stall bursts, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_seen != ctl.hold_req) begin
      hold_seen <= ctl.hold_req;
      hold_left <= LONG_HOLD;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= (hold_left == 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp.ready <= (stall_left == 1);
    end else if (!ctl.quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 19);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result(rsp.pulse_value, rsp.cell_dist, rsp.cell_interact, rsp.cell_visual);
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_req(logic kind, logic [5:0] x, logic [5:0] y, logic [5:0] z);
    req.valid <= 1'b1;
    req.req_type <= kind;
    req.cell_x <= x;
    req.cell_y <= y;
    req.cell_z <= z;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(kind, x, y, z);
    if (!ctl.quiet && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic read_cell(logic [5:0] x, logic [5:0] y, logic [5:0] z);
    push_req(REQ_READ, x, y, z);
  endtask

  task automatic tick();
    push_req(REQ_TICK, 6'($urandom), 6'($urandom), 6'($urandom));
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [DW-1:0] val);
    cfg.valid <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_near(int spread);
    read_cell(6'(MID + $urandom_range(0, 2 * spread) - spread),
              6'(MID + $urandom_range(0, 2 * spread) - spread),
              6'(MID + $urandom_range(0, 2 * spread) - spread));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before any tick: centre, corners, far cell
    read_cell(6'(MID), 6'(MID), 6'(MID));
    read_cell(6'd0, 6'd0, 6'd0);
    read_cell(6'd63, 6'd63, 6'd63);
    read_cell(6'd63, 6'd0, 6'd42);
    tick();
    read_cell(6'(MID + 1), 6'(MID), 6'(MID));
    read_cell(6'(MID), 6'(MID - 1), 6'(MID));
    read_cell(6'(MID), 6'(MID), 6'(MID + 2));
    tick();
    read_cell(6'(MID + 1), 6'(MID + 1), 6'(MID));
    read_cell(6'(MID - 2), 6'(MID), 6'(MID));
    read_cell(6'(MID), 6'(MID), 6'(MID));
    drain();

    // pulse_max at zero turns the rising pulse; floor above ceiling; wide thin shell
    write_reg(REG_PULSE_MIN, 12'd0);
    write_reg(REG_PULSE_MAX, 12'd0);
    write_reg(REG_INTERACT_WIDTH, 12'd4095);
    write_reg(REG_VISUAL_FLOOR, 12'd4095);
    write_reg(REG_VISUAL_CEILING, 12'd0);
    write_reg(3'd5, 12'd4095);
    write_reg(3'd7, 12'd0);
    tick();
    read_cell(6'(MID + 1), 6'(MID), 6'(MID + 1));
    read_cell(6'(MID), 6'(MID), 6'(MID + 3));
    read_cell(6'd0, 6'd63, 6'd0);
    // fill the block while the response side holds off
    ctl.hold_req <= ctl.hold_req + 1;
    for (int k = 0; k < 8; k++) read_near(3);
    drain();

    // top of range: falling pulse at the lower turn climbs again
    write_reg(REG_PULSE_MIN, 12'd4094);
    write_reg(REG_PULSE_MAX, 12'd4094);
    write_reg(REG_INTERACT_WIDTH, 12'd0);
    write_reg(REG_VISUAL_FLOOR, 12'd0);
    write_reg(REG_VISUAL_CEILING, 12'd4095);
    tick();
    for (int k = 0; k < 20; k++) begin
      if ($urandom_range(0, 3) == 0) read_cell(6'($urandom), 6'($urandom), 6'($urandom));
      else read_near(4);
    end
    drain();

    write_reg(REG_PULSE_MIN, 12'($urandom_range(0, 8)));
    write_reg(REG_PULSE_MAX, 12'($urandom_range(0, 40)));
    write_reg(REG_INTERACT_WIDTH, 12'($urandom_range(0, 6)));
    write_reg(REG_VISUAL_FLOOR, 12'($urandom_range(0, 9)));
    write_reg(REG_VISUAL_CEILING, 12'($urandom_range(2, 30)));
    tick();
    for (int k = 0; k < 35; k++) begin
      if ($urandom_range(0, 3) == 0) read_cell(6'($urandom), 6'($urandom), 6'($urandom));
      else read_near(5);
    end
    ctl.quiet <= 1'b1;
    for (int k = 0; k < 25; k++) read_near(5);
    req.valid <= 1'b0;

    @(posedge clk);
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d ticks and %0d cell reads, %0d responses checked",
             sb.ticks, sb.reads, sb.rsps);
    $display("register extremes, turning points, stalls and a long back-pressure hold");
    if (sb.errors == 0 && sb.pending_rsp.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
